@@ rtl/gated_frequency_counter_macros.svh @@
// Assertion macros for the gated frequency counter.
// Used by the controller; compiled out when SYNTH is defined.
`ifndef GATED_FREQUENCY_COUNTER_MACROS_SVH
`define GATED_FREQUENCY_COUNTER_MACROS_SVH

`ifndef SYNTH
`define GFC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("gated_frequency_counter assertion failed");
`define GFC_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("gated_frequency_counter forbidden condition seen");
`else
`define GFC_ASSERT(label, clk, rst, prop)
`define GFC_ASSERT_NEVER(label, clk, rst, cond)
`endif

`endif

@@ rtl/gfc_pkg.sv @@
// Shared constants and types for the gated frequency counter.
// Used by the controller, the datapath and the top level.
package gfc_pkg;

   localparam int MIN_INTERVAL_MSEC = 1000;
   localparam int TICKS_PER_MSEC    = 1000;
   localparam int MSEC_PER_SEC      = 1000;

   localparam int PERIOD_W  = 16;
   localparam int COUNT_W   = 26;
   localparam int TSS_W     = 20;
   localparam int FREQ_W    = 19;
   localparam int PRODUCT_W = 36;
   localparam int REM_W     = PERIOD_W + 1;
   localparam int DIV_STEPS = PRODUCT_W;
   localparam int STEP_W    = 6;

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [TSS_W-1:0]    MIN_INTERVAL_TICKS = TSS_W'(MIN_INTERVAL_MSEC * TICKS_PER_MSEC);
   localparam logic [PERIOD_W-1:0] PERIOD_RESET       = PERIOD_W'(1000);
   localparam logic [COUNT_W-1:0]  LIMIT_RESET        = COUNT_W'(1000 * TICKS_PER_MSEC);
   localparam logic [FREQ_W-1:0]   FREQ_MAX           = {FREQ_W{1'b1}};

   localparam logic [CSR_ADDR_W-1:0] REG_GATE_PERIOD = CSR_ADDR_W'(0);

   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_READ = 1'b1;

   typedef struct packed {
      logic accept;
      logic load_product;
      logic div_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic gate_closing;
      logic rsp_valid;
   } status_type;

endpackage

@@ rtl/gated_frequency_counter.sv @@
// Gated frequency counter. Ticks, cache hits and ignored requests are handled on acceptance;
// a tick that closes a gate gives its result after the product load and 36 steps of the
// serial restoring divider, and holds off requests until then. Reset is synchronous and
// active high: the gate period returns to 1000 ms, counters and the cached frequency clear,
// and the elapsed-time counter starts saturated.
// Depends on gfc_pkg, gfc_ctrl and gfc_dp.
module gated_frequency_counter (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [gfc_pkg::REQ_DATA_W-1:0]     req_tdata,   // pin_level, force_req, zeros
   input  logic                               req_tuser,   // kind
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [gfc_pkg::RSP_DATA_W-1:0]     rsp_tdata,   // frequency_hz, zeros
   output logic                               rsp_tuser,   // from_cache
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [gfc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [gfc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [gfc_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   gfc_pkg::cmd_type             cmd;
   gfc_pkg::status_type          status;
   logic [gfc_pkg::FREQ_W-1:0]   frequency_hz;
   logic                         cfg_write;

   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign rsp_tdata  = gfc_pkg::RSP_DATA_W'(frequency_hz);

   gfc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   gfc_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .in_kind          (req_tuser),
      .in_pin_level     (req_tdata[0]),
      .in_force_req     (req_tdata[1]),
      .cfg_write        (cfg_write),
      .cfg_addr         (csr_paddr),
      .cfg_wdata        (csr_pwdata),
      .cfg_rdata        (csr_prdata),
      .rsp_tready       (rsp_tready),
      .rsp_valid        (rsp_tvalid),
      .rsp_frequency_hz (frequency_hz),
      .rsp_from_cache   (rsp_tuser)
   );

endmodule

@@ rtl/gfc_ctrl.sv @@
// Controller state machine of the gated frequency counter.
// Depends on gfc_pkg and gated_frequency_counter_macros.svh.
`include "gated_frequency_counter_macros.svh"

module gfc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic               rsp_tready,
   input  gfc_pkg::status_type status,
   output gfc_pkg::cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MULT,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type                    state_ff, state_in;
   logic [gfc_pkg::STEP_W-1:0]   step_ff, step_in;

   assign req_tready = (state_ff == ST_IDLE) && (!status.rsp_valid || rsp_tready);

   always_comb begin
      cmd.accept       = req_tvalid && req_tready;
      cmd.load_product = (state_ff == ST_MULT);
      cmd.div_step     = (state_ff == ST_DIV);
      cmd.finish       = (state_ff == ST_DONE) && !status.rsp_valid;
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.accept && status.gate_closing) begin
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            state_in = ST_DIV;
            step_in  = '0;
         end
         ST_DIV: begin
            step_in = step_ff + 1'b1;
            if (step_ff == gfc_pkg::STEP_W'(gfc_pkg::DIV_STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!status.rsp_valid) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   `GFC_ASSERT(a_busy_no_accept, clock, reset, (state_ff != ST_IDLE) |-> !cmd.accept)
   `GFC_ASSERT(a_done_slot_free, clock, reset, (state_ff == ST_DONE) |-> !status.rsp_valid)
   `GFC_ASSERT_NEVER(a_step_range, clock, reset,
      (state_ff == ST_DIV) && (step_ff > gfc_pkg::STEP_W'(gfc_pkg::DIV_STEPS - 1)))

endmodule

@@ rtl/gfc_dp.sv @@
// Datapath of the gated frequency counter: gate state, edge counting,
// configuration register, serial divider and result register. Depends on gfc_pkg.
module gfc_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  gfc_pkg::cmd_type                  cmd,
   output gfc_pkg::status_type               status,
   input  logic                              in_kind,
   input  logic                              in_pin_level,
   input  logic                              in_force_req,
   input  logic                              cfg_write,
   input  logic [gfc_pkg::CSR_ADDR_W-1:0]    cfg_addr,
   input  logic [gfc_pkg::CSR_DATA_W-1:0]    cfg_wdata,
   output logic [gfc_pkg::CSR_DATA_W-1:0]    cfg_rdata,
   input  logic                              rsp_tready,
   output logic                              rsp_valid,
   output logic [gfc_pkg::FREQ_W-1:0]        rsp_frequency_hz,
   output logic                              rsp_from_cache
);

   logic [gfc_pkg::PERIOD_W-1:0]  period_ff, eff_period, wr_period;
   logic [gfc_pkg::COUNT_W-1:0]   limit_ff, limit_in;
   logic                          gate_open_ff, gate_open_in;
   logic [gfc_pkg::COUNT_W-1:0]   gate_ticks_ff, gate_ticks_in, ticks_next;
   logic [gfc_pkg::COUNT_W-1:0]   edge_count_ff, edge_count_in;
   logic                          prev_level_ff, prev_level_in;
   logic [gfc_pkg::TSS_W-1:0]     tss_ff, tss_in;
   logic [gfc_pkg::FREQ_W-1:0]    cached_ff, cached_in;
   logic [gfc_pkg::PRODUCT_W-1:0] quot_ff, quot_in;
   logic [gfc_pkg::REM_W-1:0]     rem_ff, rem_in, shifted, divisor;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [gfc_pkg::FREQ_W-1:0]    rsp_freq_ff, rsp_freq_in;
   logic                          rsp_cache_ff, rsp_cache_in;
   logic                          cache_hit;
   logic [gfc_pkg::FREQ_W-1:0]    final_freq;

   assign eff_period = (period_ff == '0) ? gfc_pkg::PERIOD_W'(1) : period_ff;
   assign wr_period  = (cfg_wdata[gfc_pkg::PERIOD_W-1:0] == '0) ? gfc_pkg::PERIOD_W'(1)
                       : cfg_wdata[gfc_pkg::PERIOD_W-1:0];
   assign ticks_next = gate_ticks_ff + 1'b1;
   assign divisor    = {1'b0, eff_period};
   assign shifted    = {rem_ff[gfc_pkg::REM_W-2:0], quot_ff[gfc_pkg::PRODUCT_W-1]};
   assign final_freq = (quot_ff[gfc_pkg::PRODUCT_W-1:gfc_pkg::FREQ_W] != '0)
                       ? gfc_pkg::FREQ_MAX : quot_ff[gfc_pkg::FREQ_W-1:0];

   assign cache_hit = (in_kind == gfc_pkg::KIND_READ) && !gate_open_ff && !in_force_req
                      && (tss_ff < gfc_pkg::MIN_INTERVAL_TICKS);

   assign status.gate_closing = (in_kind == gfc_pkg::KIND_TICK) && gate_open_ff
                                && (ticks_next >= limit_ff);
   assign status.rsp_valid    = rsp_valid_ff;

   assign cfg_rdata = (cfg_addr == gfc_pkg::REG_GATE_PERIOD)
                      ? gfc_pkg::CSR_DATA_W'(period_ff) : '0;

   always_comb begin
      limit_in = limit_ff;
      if (cfg_write && (cfg_addr == gfc_pkg::REG_GATE_PERIOD)) begin
         limit_in = gfc_pkg::COUNT_W'(wr_period) * gfc_pkg::COUNT_W'(gfc_pkg::TICKS_PER_MSEC);
      end
   end

   always_comb begin
      gate_open_in  = gate_open_ff;
      gate_ticks_in = gate_ticks_ff;
      edge_count_in = edge_count_ff;
      prev_level_in = prev_level_ff;
      tss_in        = tss_ff;
      if (cmd.accept) begin
         if (in_kind == gfc_pkg::KIND_TICK) begin
            if (tss_ff < gfc_pkg::MIN_INTERVAL_TICKS) begin
               tss_in = tss_ff + 1'b1;
            end
            if (gate_open_ff) begin
               if (in_pin_level != prev_level_ff) begin
                  prev_level_in = in_pin_level;
                  if (in_pin_level) begin
                     edge_count_in = edge_count_ff + 1'b1;
                  end
               end
               gate_ticks_in = ticks_next;
               if (status.gate_closing) begin
                  gate_open_in = 1'b0;
               end
            end
         end else if (!gate_open_ff && !cache_hit) begin
            gate_open_in  = 1'b1;
            gate_ticks_in = '0;
            edge_count_in = '0;
            tss_in        = '0;
         end
      end
   end

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      if (cmd.load_product) begin
         quot_in = gfc_pkg::PRODUCT_W'(edge_count_ff)
                   * gfc_pkg::PRODUCT_W'(gfc_pkg::MSEC_PER_SEC);
         rem_in  = '0;
      end else if (cmd.div_step) begin
         if (shifted >= divisor) begin
            rem_in  = shifted - divisor;
            quot_in = {quot_ff[gfc_pkg::PRODUCT_W-2:0], 1'b1};
         end else begin
            rem_in  = shifted;
            quot_in = {quot_ff[gfc_pkg::PRODUCT_W-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_freq_in  = rsp_freq_ff;
      rsp_cache_in = rsp_cache_ff;
      cached_in    = cached_ff;
      if (cmd.accept && cache_hit) begin
         rsp_valid_in = 1'b1;
         rsp_freq_in  = cached_ff;
         rsp_cache_in = 1'b1;
      end else if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         rsp_freq_in  = final_freq;
         rsp_cache_in = 1'b0;
         cached_in    = final_freq;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff     <= gfc_pkg::PERIOD_RESET;
         limit_ff      <= gfc_pkg::LIMIT_RESET;
         gate_open_ff  <= 1'b0;
         gate_ticks_ff <= '0;
         edge_count_ff <= '0;
         prev_level_ff <= 1'b0;
         tss_ff        <= gfc_pkg::MIN_INTERVAL_TICKS;
         cached_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cfg_write && (cfg_addr == gfc_pkg::REG_GATE_PERIOD)) begin
            period_ff <= cfg_wdata[gfc_pkg::PERIOD_W-1:0];
         end
         limit_ff      <= limit_in;
         gate_open_ff  <= gate_open_in;
         gate_ticks_ff <= gate_ticks_in;
         edge_count_ff <= edge_count_in;
         prev_level_ff <= prev_level_in;
         tss_ff        <= tss_in;
         cached_ff     <= cached_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff      <= quot_in;
      rem_ff       <= rem_in;
      rsp_freq_ff  <= rsp_freq_in;
      rsp_cache_ff <= rsp_cache_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frequency_hz = rsp_freq_ff;
   assign rsp_from_cache   = rsp_cache_ff;

endmodule
